/* rtl/sharp_pkg.sv */
// ----------------------------------------------------------------------------
// sharp_pkg
// Shared types and constants of the 3x3 five-point sharpen stencil.
// ----------------------------------------------------------------------------
package sharp_pkg;

   localparam int PIX_W   = 8;
   localparam int POS_W   = 12;
   localparam int CFG_W   = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CFG_W-1:0] DIM_MIN      = 13'd3;
   localparam logic [CFG_W-1:0] HEIGHT_MAX   = 13'd4096;

   // One result item on its way to the output port
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } rsp_item_type;

endpackage

/* rtl/sharp_ram.sv */
// ----------------------------------------------------------------------------
// sharp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sharp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sharp_kernel.sv */
// ----------------------------------------------------------------------------
// sharp_kernel
// Window registers and the five-point sum with clamp to 0..255.
// ----------------------------------------------------------------------------
module sharp_kernel
   import sharp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             interior,
   input  logic [PIX_W-1:0] pixel,
   input  logic [PIX_W-1:0] right,
   input  logic [PIX_W-1:0] above2,
   output logic [PIX_W-1:0] result
);

   logic [PIX_W-1:0] left_ff,   left_in;
   logic [PIX_W-1:0] centre_ff, centre_in;
   logic [PIX_W-1:0] upper_ff,  upper_in;
   logic [PIX_W-1:0] lower_ff,  lower_in;
   logic [12:0]      acc;
   logic [PIX_W-1:0] clamped;

   always_comb begin
      left_in   = left_ff;
      centre_in = centre_ff;
      upper_in  = upper_ff;
      lower_in  = lower_ff;
      if (advance) begin
         left_in   = centre_ff;
         centre_in = right;
         upper_in  = above2;
         lower_in  = pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         centre_ff <= '0;
         upper_ff  <= '0;
         lower_ff  <= '0;
      end else begin
         left_ff   <= left_in;
         centre_ff <= centre_in;
         upper_ff  <= upper_in;
         lower_ff  <= lower_in;
      end
   end

   // 5*centre - left - right - up - down, two's complement in 13 bits
   always_comb begin
      acc = 13'({centre_ff, 2'b00}) + 13'(centre_ff) - 13'(left_ff) - 13'(right)
            - 13'(upper_ff) - 13'(lower_ff);
      priority if (acc[12]) begin
         clamped = '0;
      end else if (acc[11:8] != 4'd0) begin
         clamped = '1;
      end else begin
         clamped = acc[7:0];
      end
      result = interior ? clamped : '0;
   end

endmodule

/* rtl/sharp_out.sv */
// ----------------------------------------------------------------------------
// sharp_out
// Output register with one pending slot for the right-border item.
// ----------------------------------------------------------------------------
module sharp_out
   import sharp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rsp_item_type     first,
   input  logic             two,
   input  rsp_item_type     second,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic [POS_W-1:0] rsp_out_row,
   output logic [POS_W-1:0] rsp_out_col,
   output logic             rsp_last_of_run
);

   logic         valid_ff, valid_in;
   logic         pend_ff,  pend_in;
   rsp_item_type item_ff,  item_in;
   rsp_item_type spare_ff, spare_in;

   assign free = !valid_ff || (!rsp_stall && !pend_ff);

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      item_in  = item_ff;
      spare_in = spare_ff;
      priority if (load) begin
         valid_in = 1'b1;
         pend_in  = two;
         item_in  = first;
         spare_in = second;
      end else if (valid_ff && !rsp_stall) begin
         if (pend_ff) begin
            item_in = spare_ff;
            pend_in = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end else begin
         // hold
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      item_ff  <= item_in;
      spare_ff <= spare_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_pixel   = item_ff.pixel;
   assign rsp_out_row     = item_ff.row;
   assign rsp_out_col     = item_ff.col;
   assign rsp_last_of_run = item_ff.last;

endmodule

/* rtl/sharpen_3x3_stencil_top.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_stencil_top
// Streaming 3x3 five-point Laplacian sharpen over a raster pixel stream.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in stage 1 for its line-buffer read, then its
//   result is computed into the output register, which rsp_stall can hold.
// Throughput: one item per cycle when rsp is not stalled; an item at the last
//   column also yields the zero right-border item, which holds input back.
// Reset: counters, window and handshake state clear; the line-buffer RAM is
//   not cleared, so the block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
module sharpen_3x3_stencil_top
   import sharp_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // input pixel stream
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_in,
   // result stream
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_out_pixel,
   output logic [POS_W-1:0]     rsp_out_row,
   output logic [POS_W-1:0]     rsp_out_col,
   output logic                 rsp_last_of_run,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   // --- configuration registers ---------------------------------------------
   logic [CFG_W-1:0] width_ff,  width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             restart;

   // --- position of the next item -------------------------------------------
   logic [CW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;

   // --- stage 1: item waiting for its line-buffer read -----------------------
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff,   s1_pix_in;
   logic [CW-1:0]    s1_col_ff,   s1_col_in;
   logic [POS_W-1:0] s1_row_ff,   s1_row_in;
   logic             s1_emit_ff,  s1_emit_in;
   logic             s1_inner_ff, s1_inner_in;
   logic             s1_two_ff,   s1_two_in;

   logic [31:0]      w_ext;
   logic [CFG_W-1:0] h_ext;
   logic [CW-1:0]    last_col;
   logic [POS_W-1:0] last_row;
   logic [CW-1:0]    col_use;
   logic [POS_W-1:0] row_use;
   logic             accept;
   logic             s1_fire;
   logic             out_free;

   logic [2*PIX_W-1:0] rd_data;
   logic [PIX_W-1:0]   right;
   logic [PIX_W-1:0]   above2;
   logic [PIX_W-1:0]   result;
   rsp_item_type       first;
   rsp_item_type       second;

   // Effective frame size: clamp to 3..MAX_WIDTH and 3..4096
   always_comb begin
      w_ext = 32'(width_ff);
      if (w_ext < 32'(DIM_MIN)) begin
         w_ext = 32'(DIM_MIN);
      end
      if (w_ext > 32'(MAX_WIDTH)) begin
         w_ext = 32'(MAX_WIDTH);
      end
      last_col = CW'(w_ext - 32'd1);

      h_ext = height_ff;
      if (h_ext < DIM_MIN) begin
         h_ext = DIM_MIN;
      end
      if (h_ext > HEIGHT_MAX) begin
         h_ext = HEIGHT_MAX;
      end
      last_row = POS_W'(h_ext - 13'd1);
   end

   // Registers take writes at any time; the frame restarts on a known index
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // Handshake: stage 1 drains when its item leaves no result or the output
   // register has room for it; a new item enters only when stage 1 is empty or drains.
   assign s1_fire   = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   // Position of the incoming item and of the one after it
   always_comb begin
      col_use = (col_ff > last_col) ? '0 : col_ff;
      row_use = (row_ff > last_row) ? '0 : row_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_use == last_col) begin
            col_in = '0;
            row_in = (row_use == last_row) ? '0 : row_use + POS_W'(1);
         end else begin
            col_in = col_use + CW'(1);
            row_in = row_use;
         end
      end
   end

   // Stage 1 load: the item's result is for (row-1, col-1)
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pix_in   = s1_pix_ff;
      s1_col_in   = s1_col_ff;
      s1_row_in   = s1_row_ff;
      s1_emit_in  = s1_emit_ff;
      s1_inner_in = s1_inner_ff;
      s1_two_in   = s1_two_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pix_in   = req_pixel_in;
         s1_col_in   = col_use;
         s1_row_in   = row_use;
         s1_emit_in  = (row_use != '0) && (col_use != '0);
         // neither the top row nor the left column of the output frame
         s1_inner_in = (row_use > POS_W'(1)) && (col_use > CW'(1));
         s1_two_in   = (col_use == last_col);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_pix_ff   <= s1_pix_in;
      s1_col_ff   <= s1_col_in;
      s1_row_ff   <= s1_row_in;
      s1_emit_ff  <= s1_emit_in;
      s1_inner_ff <= s1_inner_in;
      s1_two_ff   <= s1_two_in;
   end

   // Both line buffers share one RAM word per column: the row above in the
   // upper byte, the row two above in the lower byte. Read on accept, write
   // back when the item leaves stage 1; the next read of the same column is
   // a whole row later, so no forwarding is needed.
   sharp_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_pix_ff, right}),
      .rd_en   (accept),
      .rd_addr (col_use),
      .rd_data (rd_data)
   );

   assign right  = rd_data[2*PIX_W-1:PIX_W];
   assign above2 = rd_data[PIX_W-1:0];

   sharp_kernel u_kernel (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_fire),
      .interior (s1_inner_ff),
      .pixel    (s1_pix_ff),
      .right    (right),
      .above2   (above2),
      .result   (result)
   );

   // Result items: the stencil value, then at the last column the zero
   // right-border item at the same row
   always_comb begin
      first.pixel  = result;
      first.row    = s1_row_ff - POS_W'(1);
      first.col    = POS_W'(32'(s1_col_ff - CW'(1)));
      first.last   = !s1_two_ff;
      second.pixel = '0;
      second.row   = s1_row_ff - POS_W'(1);
      second.col   = POS_W'(32'(s1_col_ff));
      second.last  = 1'b1;
   end

   sharp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (s1_fire && s1_emit_ff),
      .first           (first),
      .two             (s1_two_ff),
      .second          (second),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* tb/sharpen_3x3_stencil_top_tb.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_stencil_top_tb
// Self-checking bench for the streaming 3x3 five-point sharpen stencil.
// Pixels go in through a valid/stall channel and frame sizes through the
// register port. A local model of the line buffers and window predicts every
// sharpened item, and each item leaving the block is checked field by field.
// Directed frames cover the borders, both clamps and ignored register writes.
// Random frames of many sizes follow, with idling on both sides, a long
// receiver hold-off and a short run at the widest row.
// ----------------------------------------------------------------------------
module sharpen_3x3_stencil_top_tb;
   import sharp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_MAX = 4096;

   // indexes past the end of the register list: written, but must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   // cycles to let pass after the last item before a register write
   localparam int unsigned SETTLE_CYCLES = 4;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic [POS_W-1:0]     rsp_out_row;
   logic [POS_W-1:0]     rsp_out_col;
   logic                 rsp_last_of_run;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   sharpen_3x3_stencil_top #(
      .MAX_WIDTH (LINE_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // -------------------------------------------------------------------------
   // Local copy of the block's state
   // -------------------------------------------------------------------------
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic [PIX_W-1:0] line_two_above [LINE_MAX];
   logic [PIX_W-1:0] line_above     [LINE_MAX];
   logic [PIX_W-1:0] win_left;
   logic [PIX_W-1:0] win_centre;
   logic [PIX_W-1:0] win_up;
   logic [PIX_W-1:0] win_down;
   int unsigned      next_col;
   int unsigned      next_row;

   // sharpened items still owed by the block, oldest first
   rsp_item_type sharpened_q[$];

   int unsigned error_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_off_left;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v,
                                           input int unsigned cap);
      // sizes outside the legal span are pulled to the nearest end
      if (v < DIM_MIN) return DIM_MIN;
      if (v > cap) return cap;
      return v;
   endfunction

   function automatic void reset_model();
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      for (int i = 0; i < LINE_MAX; i++) begin
         line_two_above[i] = '0;
         line_above[i]     = '0;
      end
      win_left   = '0;
      win_centre = '0;
      win_up     = '0;
      win_down   = '0;
      next_col   = 0;
      next_row   = 0;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
      case (idx)
         REG_IMAGE_WIDTH: begin
            cfg_width = data;
         end
         REG_IMAGE_HEIGHT: begin
            cfg_height = data;
         end
         default: begin
            // spare index: no effect, and no restart of the frame
            return;
         end
      endcase
      // any real write starts a fresh frame; line buffers are kept
      next_col = 0;
      next_row = 0;
   endfunction

   // Advance the window by one pixel and queue the items it releases.
   function automatic void predict_sharpened(input logic [PIX_W-1:0] pix);
      int unsigned  w;
      int unsigned  h;
      int unsigned  c;
      int unsigned  r;
      logic [PIX_W-1:0] right;
      logic [PIX_W-1:0] above2;
      int           lap;
      rsp_item_type item;
      w = eff_dim(cfg_width, LINE_MAX);
      h = eff_dim(cfg_height, HEIGHT_MAX);
      c = (next_col >= w) ? 0 : next_col;
      r = (next_row >= h) ? 0 : next_row;
      right  = line_above[c];
      above2 = line_two_above[c];

      // pixel (r-1, c-1) is complete once (r, c) arrives
      if (r >= 1 && c >= 1) begin
         lap = 0;
         if (r != 1 && c != 1) begin
            lap = 5 * int'(win_centre) - int'(win_left) - int'(right)
                  - int'(win_up) - int'(win_down);
            if (lap < 0) lap = 0;
            if (lap > 255) lap = 255;
         end
         item.pixel = PIX_W'(lap);
         item.row   = POS_W'(r - 1);
         item.col   = POS_W'(c - 1);
         item.last  = (c != w - 1);
         sharpened_q.push_back(item);
         // last column: the zero right-border pixel trails behind
         if (c == w - 1) begin
            item.pixel = '0;
            item.col   = POS_W'(w - 1);
            item.last  = 1'b1;
            sharpened_q.push_back(item);
         end
      end

      win_left          = win_centre;
      win_centre        = right;
      win_up            = above2;
      win_down          = pix;
      line_two_above[c] = right;
      line_above[c]     = pix;

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r;
   endfunction

   // -------------------------------------------------------------------------
   // Result side: check each accepted item, then pick the next stall
   // -------------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_side
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sharpened_q.size() == 0) begin
            $error("unexpected item: row %0d col %0d pixel %0d",
                   rsp_out_row, rsp_out_col, rsp_out_pixel);
            error_count++;
         end else begin
            want = sharpened_q.pop_front();
            check_field("out_pixel", want.pixel, rsp_out_pixel);
            check_field("out_row", want.row, rsp_out_row);
            check_field("out_col", want.col, rsp_out_col);
            check_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
      // a hold-off request overrides the random stall pattern
      if (hold_off_left != 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Input side helpers
   // -------------------------------------------------------------------------
   function automatic logic [PIX_W-1:0] pick_pixel();
      // lean on the extremes so both clamps get hit often
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim(input int unsigned hi);
      case ($urandom_range(9))
         0:       return CFG_W'($urandom_range(2));
         1:       return CFG_W'($urandom_range(3, 2 * hi));
         default: return CFG_W'($urandom_range(3, hi));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sharpened(pix);
   endtask

   // Drop valid, wait for every owed item, then give the pipe time to empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (sharpened_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset size is 640 wide: a handful of pixels stays in row 0 and
   // must release nothing.
   task automatic test_reset_size();
      repeat (8) send_pixel(pick_pixel());
      settle_block();
   endtask

   // Smallest frame via out-of-range sizes, one hot centre and one cold
   // centre, two ignored writes mid-frame, and a wrap into the next frame.
   task automatic test_border_and_clamp();
      logic [PIX_W-1:0] hot  [9];
      logic [PIX_W-1:0] cold [9];
      for (int i = 0; i < 9; i++) begin
         hot[i]  = (i == 4) ? 8'd255 : 8'd0;
         cold[i] = (i == 4) ? 8'd0 : 8'd255;
      end
      write_csr(REG_IMAGE_WIDTH, 13'd0);
      write_csr(REG_IMAGE_HEIGHT, 13'd2);
      for (int i = 0; i < 4; i++) send_pixel(hot[i]);
      // spare indexes must neither change the size nor restart the frame
      settle_block();
      write_csr(REG_SPARE_2, CFG_W'($urandom));
      write_csr(REG_SPARE_3, CFG_W'($urandom));
      for (int i = 4; i < 9; i++) send_pixel(hot[i]);
      for (int i = 0; i < 9; i++) send_pixel(cold[i]);
      settle_block();
   endtask

   // Mostly whole frames of random content, some broken off part-way by the
   // next register write.
   task automatic test_random_frames(input int unsigned n_items);
      int unsigned      sent;
      int unsigned      frame;
      int unsigned      burst;
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;
      sent = 0;
      while (sent < n_items) begin
         w_val = pick_dim(10);
         h_val = pick_dim(5);
         case ($urandom_range(3))
            0: begin
               write_csr(REG_IMAGE_WIDTH, w_val);
               write_csr(REG_IMAGE_HEIGHT, h_val);
            end
            1: begin
               write_csr(REG_IMAGE_HEIGHT, h_val);
               write_csr(REG_IMAGE_WIDTH, w_val);
            end
            2: begin
               write_csr(REG_IMAGE_WIDTH, w_val);
            end
            default: begin
               write_csr(REG_IMAGE_HEIGHT, h_val);
            end
         endcase
         if ($urandom_range(4) == 0)
            write_csr($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
         frame = eff_dim(cfg_width, LINE_MAX) * eff_dim(cfg_height, HEIGHT_MAX);
         if ($urandom_range(9) < 3)
            burst = $urandom_range(1, frame);
         else
            burst = frame * $urandom_range(1, 2);
         // keep to the item budget of this test
         if (burst > n_items - sent)
            burst = n_items - sent;
         repeat (burst) send_pixel(pick_pixel());
         sent += burst;
         settle_block();
      end
   endtask

   // Hold the result side off for a long stretch while pixels keep coming,
   // so the block fills and has to stall its input.
   task automatic test_backpressure();
      int unsigned saved_idle;
      saved_idle = send_idle_pct;
      write_csr(REG_IMAGE_WIDTH, 13'd4);
      write_csr(REG_IMAGE_HEIGHT, 13'd5);
      send_idle_pct = 0;
      hold_off_left = 150;
      repeat (60) send_pixel(pick_pixel());
      send_idle_pct = saved_idle;
      settle_block();
   endtask

   // Oversized registers clamp to the widest row; a short run stays in
   // row 0 of that frame and must release nothing.
   task automatic test_widest_row();
      write_csr(REG_IMAGE_WIDTH, '1);
      write_csr(REG_IMAGE_HEIGHT, '1);
      repeat (24) send_pixel(pick_pixel());
      settle_block();
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_in  = '0;
      csr_valid     = 1'b0;
      csr_index     = REG_IMAGE_WIDTH;
      csr_data      = '0;
      error_count   = 0;
      hold_off_left = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 34;
      recv_idle_pct = 52;
      test_reset_size();
      test_border_and_clamp();
      test_random_frames(150);

      // and the other way round
      send_idle_pct = 52;
      recv_idle_pct = 34;
      test_backpressure();
      test_random_frames(150);

      // flat out
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_widest_row();
      test_random_frames(40);

      req_valid <= 1'b0;
      for (int i = 0; i < 20000 && sharpened_q.size() != 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sharpened_q.size() != 0) begin
         $error("%0d items never arrived", sharpened_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/sharp_pkg.sv
rtl/sharp_ram.sv
rtl/sharp_kernel.sv
rtl/sharp_out.sv
rtl/sharpen_3x3_stencil_top.sv
tb/sharpen_3x3_stencil_top_tb.sv
